// File: src/plnp_pkg.sv
package plnp_pkg;

	localparam int PLNP_COORD_W = 24;
	localparam int PLNP_DIST_W  = 50;
	localparam int PLNP_CFG_IDX_W = 1;

	localparam logic [PLNP_CFG_IDX_W-1:0] CFG_TARGET_X = 1'b0;
	localparam logic [PLNP_CFG_IDX_W-1:0] CFG_TARGET_Y = 1'b1;

	localparam logic [63:0] PLNP_DIST_SAT = 64'd1 << (PLNP_DIST_W - 1);

	typedef enum logic [2:0] {
		MOP_DXDX,
		MOP_DYDY,
		MOP_WXDX,
		MOP_WYDY,
		MOP_EXEX,
		MOP_EYEY,
		MOP_FXFX,
		MOP_FYFY
	} plnp_mop_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_DEN_SET,
		ACC_DEN_ADD,
		ACC_NUM_SET,
		ACC_NUM_ADD,
		ACC_DIST_SET,
		ACC_DIST_ADD
	} plnp_acc_t;

	typedef struct packed {
		logic      load;
		logic      diff;
		plnp_mop_t mop;
		plnp_acc_t acc;
		logic      vupd;
		logic      foot_start;
		logic      fdiff;
		logic      fupd;
		logic      out_load;
	} plnp_cmd_t;

	typedef struct packed {
		logic last;
		logic seg_ok;
		logic foot_done;
	} plnp_stat_t;

endpackage

// File: src/plnp_in_if.sv
interface plnp_in_if import plnp_pkg::*; #(
	parameter int COORD_WIDTH = PLNP_COORD_W
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vertex_x;
	logic signed [COORD_WIDTH-1:0] vertex_y;
	logic                          first_vertex;
	logic                          last_vertex;

	modport source (output valid, vertex_x, vertex_y, first_vertex, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, first_vertex, last_vertex, output ready);
endinterface

// File: src/plnp_out_if.sv
interface plnp_out_if import plnp_pkg::*; #(
	parameter int COORD_WIDTH = PLNP_COORD_W
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] nearest_x;
	logic signed [COORD_WIDTH-1:0] nearest_y;
	logic [PLNP_DIST_W-1:0]        nearest_dist_sq;
	logic                          on_segment;

	modport source (output valid, nearest_x, nearest_y, nearest_dist_sq, on_segment, input ready);
	modport sink (input valid, nearest_x, nearest_y, nearest_dist_sq, on_segment, output ready);
endinterface

// File: src/plnp_foot.sv
module plnp_foot import plnp_pkg::*; #(
	parameter int COORD_WIDTH = PLNP_COORD_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] p,
	input  logic signed [COORD_WIDTH:0]   c,
	input  logic [2*COORD_WIDTH+1:0]      num,
	input  logic [2*COORD_WIDTH+1:0]      den,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] coord
);
	localparam int W  = COORD_WIDTH;
	localparam int NW = 2*W + 2;
	localparam int PW = 3*W + 3;
	localparam int RW = 2*W + 3;
	localparam int CW = $clog2(W + 2);

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV} fstate_t;

	fstate_t               state_q;
	logic [CW-1:0]         cnt_q;
	logic [W:0]            m_q;
	logic                  neg_q;
	logic signed [W-1:0]   p_q;
	logic [NW-1:0]         num_q;
	logic [NW-1:0]         den_q;
	logic [PW-1:0]         prod_q;
	logic [RW-1:0]         r_q;
	logic [W:0]            n_q;
	logic [W:0]            quo_q;
	logic                  done_q;

	logic [W:0]            mabs;
	logic [PW:0]           nfull;
	logic [RW:0]           r2;
	logic [RW:0]           dsh;
	logic                  ge;
	logic [W+1:0]          sum;

	always_comb begin
		mabs  = c[W] ? (W+1)'(-c) : (W+1)'(c);
		nfull = {prod_q, 1'b0} + (PW+1)'(den_q);
		r2    = {r_q, n_q[W]};
		dsh   = {1'b0, den_q, 1'b0};
		ge    = (r2 >= dsh);
		if (neg_q) begin
			sum = {{2{p_q[W-1]}}, p_q} - {1'b0, quo_q};
		end else begin
			sum = {{2{p_q[W-1]}}, p_q} + {1'b0, quo_q};
		end
		coord = sum[W-1:0];
		done  = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == F_DIV) && (cnt_q == CW'(W + 1));
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_MUL;
						cnt_q   <= '0;
					end
				end
				F_MUL: begin
					if (cnt_q == CW'(W + 1)) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				F_DIV: begin
					if (cnt_q == CW'(W + 1)) begin
						state_q <= F_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			m_q    <= mabs;
			neg_q  <= c[W];
			p_q    <= p;
			num_q  <= num;
			den_q  <= den;
			prod_q <= '0;
			quo_q  <= '0;
		end else if (state_q == F_MUL) begin
			if (cnt_q == CW'(W + 1)) begin
				r_q <= nfull[PW:W+1];
				n_q <= nfull[W:0];
			end else begin
				prod_q <= {prod_q[PW-2:0], 1'b0} + (m_q[W] ? PW'(num_q) : '0);
				m_q    <= {m_q[W-1:0], 1'b0};
			end
		end else if (state_q == F_DIV && cnt_q != CW'(W + 1)) begin
			r_q   <= ge ? RW'(r2 - dsh) : RW'(r2);
			quo_q <= {quo_q[W-1:0], ge};
			n_q   <= {n_q[W-1:0], 1'b0};
		end
	end
endmodule

// File: src/plnp_datapath.sv
module plnp_datapath import plnp_pkg::*; #(
	parameter int COORD_WIDTH = PLNP_COORD_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [PLNP_CFG_IDX_W-1:0]     wr_index,
	input  logic [COORD_WIDTH-1:0]        wr_data,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic                          in_first,
	input  logic                          in_last,
	input  plnp_cmd_t                     cmd,
	output plnp_stat_t                    stat,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic [PLNP_DIST_W-1:0]        out_dist,
	output logic                          out_seg
);
	localparam int W   = COORD_WIDTH;
	localparam int AW  = 2*W + 3;
	localparam int DW  = PLNP_DIST_W;
	localparam int EW  = (AW > DW) ? AW : DW;
	localparam logic [DW-1:0] DIST_ONES = '1;

	logic signed [W-1:0]  tx_q, ty_q;
	logic signed [W-1:0]  x_q, y_q, prev_x_q, prev_y_q;
	logic                 last_q, has_prev_q;
	logic signed [W:0]    dx_q, dy_q, wx_q, wy_q, ex_q, ey_q, efx_q, efy_q;
	logic signed [2*W+1:0] prod_q;
	logic signed [AW-1:0] den_q, num_q, dist_q;
	logic signed [W-1:0]  bvx_q, bvy_q, bfx_q, bfy_q;
	logic [DW-1:0]        bvd_q, bfd_q;
	logic                 found_q;

	logic signed [W:0]    opa;
	logic [EW-1:0]        dext;
	logic [DW-1:0]        dsat;
	logic signed [W-1:0]  fx, fy;
	logic                 fx_done, fy_done;
	logic                 use_foot;

	function automatic logic signed [W:0] opa_b(input plnp_mop_t mop);
		case (mop)
			MOP_WXDX: opa_b = dx_q;
			MOP_WYDY: opa_b = dy_q;
			default:  opa_b = opa;
		endcase
	endfunction

	always_comb begin
		case (cmd.mop)
			MOP_DXDX: opa = dx_q;
			MOP_DYDY: opa = dy_q;
			MOP_WXDX: opa = wx_q;
			MOP_WYDY: opa = wy_q;
			MOP_EXEX: opa = ex_q;
			MOP_EYEY: opa = ey_q;
			MOP_FXFX: opa = efx_q;
			MOP_FYFY: opa = efy_q;
			default:  opa = '0;
		endcase
		dext = EW'(unsigned'(dist_q));
		dsat = (dext > EW'(PLNP_DIST_SAT)) ? DW'(PLNP_DIST_SAT) : DW'(dext);
		stat.last      = last_q;
		stat.seg_ok    = has_prev_q && (den_q > 0) && (num_q > 0) && (num_q < den_q);
		stat.foot_done = fx_done && fy_done;
		use_foot = found_q && (bfd_q < bvd_q);
	end

	plnp_foot #(.COORD_WIDTH(W)) u_foot_x (
		.clk, .arst_n,
		.start (cmd.foot_start),
		.p     (prev_x_q),
		.c     (dx_q),
		.num   ((2*W+2)'(num_q)),
		.den   ((2*W+2)'(den_q)),
		.done  (fx_done),
		.coord (fx)
	);

	plnp_foot #(.COORD_WIDTH(W)) u_foot_y (
		.clk, .arst_n,
		.start (cmd.foot_start),
		.p     (prev_y_q),
		.c     (dy_q),
		.num   ((2*W+2)'(num_q)),
		.den   ((2*W+2)'(den_q)),
		.done  (fy_done),
		.coord (fy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q     <= '0;
			ty_q     <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			bvx_q    <= '0;
			bvy_q    <= '0;
			bvd_q    <= DIST_ONES;
			bfx_q    <= '0;
			bfy_q    <= '0;
			bfd_q    <= DIST_ONES;
			found_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_index == CFG_TARGET_X) begin
					tx_q <= wr_data;
				end else if (wr_index == CFG_TARGET_Y) begin
					ty_q <= wr_data;
				end
			end
			if (cmd.load && in_first) begin
				bvx_q   <= '0;
				bvy_q   <= '0;
				bvd_q   <= DIST_ONES;
				bfx_q   <= '0;
				bfy_q   <= '0;
				bfd_q   <= DIST_ONES;
				found_q <= 1'b0;
			end
			if (cmd.vupd) begin
				if (dsat < bvd_q) begin
					bvx_q <= x_q;
					bvy_q <= y_q;
					bvd_q <= dsat;
				end
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end
			if (cmd.fupd && dsat < bfd_q) begin
				bfx_q   <= fx;
				bfy_q   <= fy;
				bfd_q   <= dsat;
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opa_b(cmd.mop);
		if (cmd.load) begin
			x_q    <= in_x;
			y_q    <= in_y;
			last_q <= in_last;
		end
		if (cmd.diff) begin
			dx_q       <= {x_q[W-1], x_q} - {prev_x_q[W-1], prev_x_q};
			dy_q       <= {y_q[W-1], y_q} - {prev_y_q[W-1], prev_y_q};
			wx_q       <= {tx_q[W-1], tx_q} - {prev_x_q[W-1], prev_x_q};
			wy_q       <= {ty_q[W-1], ty_q} - {prev_y_q[W-1], prev_y_q};
			ex_q       <= {x_q[W-1], x_q} - {tx_q[W-1], tx_q};
			ey_q       <= {y_q[W-1], y_q} - {ty_q[W-1], ty_q};
			has_prev_q <= (bvd_q != DIST_ONES);
		end
		if (cmd.fdiff) begin
			efx_q <= {fx[W-1], fx} - {tx_q[W-1], tx_q};
			efy_q <= {fy[W-1], fy} - {ty_q[W-1], ty_q};
		end
		case (cmd.acc)
			ACC_DEN_SET:  den_q  <= AW'(prod_q);
			ACC_DEN_ADD:  den_q  <= den_q + AW'(prod_q);
			ACC_NUM_SET:  num_q  <= AW'(prod_q);
			ACC_NUM_ADD:  num_q  <= num_q + AW'(prod_q);
			ACC_DIST_SET: dist_q <= AW'(prod_q);
			ACC_DIST_ADD: dist_q <= dist_q + AW'(prod_q);
			default: ;
		endcase
		if (cmd.out_load) begin
			out_x    <= use_foot ? bfx_q : bvx_q;
			out_y    <= use_foot ? bfy_q : bvy_q;
			out_dist <= use_foot ? bfd_q : bvd_q;
			out_seg  <= use_foot;
		end
	end
endmodule

// File: src/plnp_ctrl.sv
module plnp_ctrl import plnp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  plnp_stat_t stat,
	output plnp_cmd_t  cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_VUPD,
		S_FOOT, S_F0, S_F1, S_F2, S_F3, S_FUPD, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	always_comb begin
		out_free       = !out_valid_q || out_ready;
		in_ready       = (state_q == S_IDLE);
		out_valid      = out_valid_q;
		cmd            = '0;
		cmd.mop        = MOP_DXDX;
		cmd.acc        = ACC_NONE;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		case (state_q)
			S_DIFF: cmd.diff = 1'b1;
			S_M0:   cmd.mop  = MOP_DXDX;
			S_M1: begin
				cmd.mop = MOP_DYDY;
				cmd.acc = ACC_DEN_SET;
			end
			S_M2: begin
				cmd.mop = MOP_WXDX;
				cmd.acc = ACC_DEN_ADD;
			end
			S_M3: begin
				cmd.mop = MOP_WYDY;
				cmd.acc = ACC_NUM_SET;
			end
			S_M4: begin
				cmd.mop = MOP_EXEX;
				cmd.acc = ACC_NUM_ADD;
			end
			S_M5: begin
				cmd.mop = MOP_EYEY;
				cmd.acc = ACC_DIST_SET;
			end
			S_M6: cmd.acc = ACC_DIST_ADD;
			S_VUPD: begin
				cmd.vupd       = 1'b1;
				cmd.foot_start = stat.seg_ok;
			end
			S_F0:   cmd.fdiff = 1'b1;
			S_F1:   cmd.mop   = MOP_FXFX;
			S_F2: begin
				cmd.mop = MOP_FYFY;
				cmd.acc = ACC_DIST_SET;
			end
			S_F3:   cmd.acc  = ACC_DIST_ADD;
			S_FUPD: cmd.fupd = 1'b1;
			S_DONE: cmd.out_load = stat.last && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DIFF;
				S_DIFF: state_q <= S_M0;
				S_M0:   state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_M3;
				S_M3:   state_q <= S_M4;
				S_M4:   state_q <= S_M5;
				S_M5:   state_q <= S_M6;
				S_M6:   state_q <= S_VUPD;
				S_VUPD: state_q <= stat.seg_ok ? S_FOOT : S_DONE;
				S_FOOT: if (stat.foot_done) state_q <= S_F0;
				S_F0:   state_q <= S_F1;
				S_F1:   state_q <= S_F2;
				S_F2:   state_q <= S_F3;
				S_F3:   state_q <= S_FUPD;
				S_FUPD: state_q <= S_DONE;
				S_DONE: begin
					if (!stat.last || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/polyline_nearest_point_core.sv
// Nearest point of a polyline to a target point held in the CFG_TARGET_X/Y registers. Vertices
// arrive one item at a time; one result item follows each vertex marked last_vertex.
// A vertex whose segment has an interior foot goes on to the bit-serial multiply and
// restoring divide in the two foot units before the next vertex is taken; a vertex
// that forms no interior foot skips them.
// Vertices are taken while a result waits at the output register; a last vertex holds
// in its final cycle until that register is free.
module polyline_nearest_point_core import plnp_pkg::*; #(
	parameter int COORD_WIDTH = PLNP_COORD_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [PLNP_CFG_IDX_W-1:0] wr_index,
	input  logic [COORD_WIDTH-1:0]    wr_data,
	plnp_in_if.sink                   vertices,
	plnp_out_if.source                nearest
);
	plnp_cmd_t  cmd;
	plnp_stat_t stat;

	plnp_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid  (vertices.valid),
		.in_ready  (vertices.ready),
		.out_valid (nearest.valid),
		.out_ready (nearest.ready),
		.stat,
		.cmd
	);

	plnp_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk, .arst_n,
		.wr_en, .wr_index, .wr_data,
		.in_x     (vertices.vertex_x),
		.in_y     (vertices.vertex_y),
		.in_first (vertices.first_vertex),
		.in_last  (vertices.last_vertex),
		.cmd,
		.stat,
		.out_x    (nearest.nearest_x),
		.out_y    (nearest.nearest_y),
		.out_dist (nearest.nearest_dist_sq),
		.out_seg  (nearest.on_segment)
	);
endmodule

// File: src/plnp_checker.sv
module plnp_checker import plnp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [PLNP_DIST_W-1:0] dist_sq
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result item dropped");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken during work");

	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dist_sq <= PLNP_DIST_W'(PLNP_DIST_SAT))
		else $error("distance not saturated");
endmodule

bind polyline_nearest_point_core plnp_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertices.valid),
	.in_ready  (vertices.ready),
	.out_valid (nearest.valid),
	.out_ready (nearest.ready),
	.dist_sq   (nearest.nearest_dist_sq)
);

// File: tb/sv/polyline_nearest_point_core_tb.sv
module polyline_nearest_point_core_tb;
	import plnp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = PLNP_COORD_W;
	localparam int DW = PLNP_DIST_W;
	localparam logic [DW-1:0] DIST_ONES = '1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [DW-1:0]        dist_sq;
		logic                 on_seg;
	} nearest_t;

	typedef struct {
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic                 first;
		logic                 last;
		logic                 check;
		nearest_t             want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [PLNP_CFG_IDX_W-1:0] wr_index;
	logic [CW-1:0] wr_data;
	int fails;
	int idle_pct;
	int stall_pct;

	plnp_in_if  vertices();
	plnp_out_if nearest();

	polyline_nearest_point_core uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .vertices(vertices), .nearest(nearest)
	);

	longint tgt_x, tgt_y;
	longint prv_x, prv_y;
	longint bv_x, bv_y, bf_x, bf_y;
	logic [DW-1:0] bv_dist, bf_dist;
	bit foot_seen;
	nearest_t nearest_q[$];

	function automatic logic [DW-1:0] sq_dist(longint ax, longint ay, longint bx, longint by);
		logic signed [127:0] s;
		s = 128'(ax - bx) * 128'(ax - bx) + 128'(ay - by) * 128'(ay - by);
		if (s > 128'(PLNP_DIST_SAT)) return DW'(PLNP_DIST_SAT);
		return DW'(s);
	endfunction

	function automatic longint foot_at(longint p, longint c, logic signed [127:0] num,
			logic signed [127:0] den);
		logic [127:0] m, q;
		m = (c < 0) ? 128'(-c) : 128'(c);
		q = (2 * m * num + den) / (2 * den);
		return (c < 0) ? p - longint'(q) : p + longint'(q);
	endfunction

	function automatic void clear_bests();
		bv_x = 0; bv_y = 0; bv_dist = DIST_ONES;
		bf_x = 0; bf_y = 0; bf_dist = DIST_ONES;
		foot_seen = 0;
	endfunction

	function automatic bit track_vertex(logic signed [CW-1:0] vx, logic signed [CW-1:0] vy,
			logic first, logic last, output nearest_t res);
		longint x, y, dx, dy, wx, wy, fx, fy;
		logic signed [127:0] num, den;
		logic [DW-1:0] d;
		x = vx; y = vy;
		if (first) clear_bests();
		if (bv_dist != DIST_ONES) begin
			dx = x - prv_x; dy = y - prv_y;
			wx = tgt_x - prv_x; wy = tgt_y - prv_y;
			den = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
			num = 128'(wx) * 128'(dx) + 128'(wy) * 128'(dy);
			if (den != 0 && num > 0 && num < den) begin
				fx = foot_at(prv_x, dx, num, den);
				fy = foot_at(prv_y, dy, num, den);
				d = sq_dist(fx, fy, tgt_x, tgt_y);
				if (d < bf_dist) begin
					bf_x = fx; bf_y = fy; bf_dist = d; foot_seen = 1;
				end
			end
		end
		d = sq_dist(x, y, tgt_x, tgt_y);
		if (d < bv_dist) begin
			bv_x = x; bv_y = y; bv_dist = d;
		end
		prv_x = x; prv_y = y;
		if (!last) return 0;
		if (foot_seen && bf_dist < bv_dist)
			res = '{x: CW'(bf_x), y: CW'(bf_y), dist_sq: bf_dist, on_seg: 1'b1};
		else
			res = '{x: CW'(bv_x), y: CW'(bv_y), dist_sq: bv_dist, on_seg: 1'b0};
		return 1;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("polyline_nearest_point_core: mismatch");
		$finish;
	end

	initial begin
		nearest.ready = 0;
		forever begin
			@(negedge clk);
			nearest.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		nearest_t got, want;
		if (arst_n && nearest.valid && nearest.ready) begin
			got = '{x: nearest.nearest_x, y: nearest.nearest_y,
				dist_sq: nearest.nearest_dist_sq, on_seg: nearest.on_segment};
			if (nearest_q.size() == 0) begin
				$error("unexpected item x=%0d y=%0d", got.x, got.y);
				fails++;
			end else begin
				want = nearest_q.pop_front();
				if (got.x !== want.x) begin
					$error("nearest_x expected %0d got %0d", want.x, got.x); fails++;
				end
				if (got.y !== want.y) begin
					$error("nearest_y expected %0d got %0d", want.y, got.y); fails++;
				end
				if (got.dist_sq !== want.dist_sq) begin
					$error("nearest_dist_sq expected %0d got %0d", want.dist_sq,
						got.dist_sq);
					fails++;
				end
				if (got.on_seg !== want.on_seg) begin
					$error("on_segment expected %0d got %0d", want.on_seg, got.on_seg);
					fails++;
				end
			end
		end
	end

	task automatic write_reg(logic [PLNP_CFG_IDX_W-1:0] idx, longint val);
		@(negedge clk);
		wr_en <= 1; wr_index <= idx; wr_data <= CW'(val);
		@(negedge clk);
		wr_en <= 0;
		if (idx == CFG_TARGET_X) tgt_x = longint'(signed'(CW'(val)));
		else tgt_y = longint'(signed'(CW'(val)));
	endtask

	task automatic send_vertex(logic signed [CW-1:0] vx, logic signed [CW-1:0] vy,
			logic first, logic last, logic check, nearest_t want);
		nearest_t res;
		nearest_t exp_item;
		while ($urandom_range(99) < idle_pct) begin
			vertices.valid <= 0;
			@(negedge clk);
		end
		vertices.valid <= 1;
		vertices.vertex_x <= vx; vertices.vertex_y <= vy;
		vertices.first_vertex <= first; vertices.last_vertex <= last;
		do @(posedge clk); while (!vertices.ready);
		if (track_vertex(vx, vy, first, last, res)) begin
			if (check && res !== want) begin
				$error("predictor disagrees with typed row x=%0d", vx); fails++;
			end
			exp_item = check ? want : res;
			nearest_q = {nearest_q, exp_item};
		end
		@(negedge clk);
	endtask

	task automatic drain();
		vertices.valid <= 0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int span);
		case ($urandom_range(9))
			0: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			1: return CW'($urandom);
			default: return CW'($signed($urandom_range(2 * span)) - span);
		endcase
	endfunction

	dir_row_t dir_rows[$];

	initial begin
		nearest_t none;
		int n, len, span;
		none = '0;
		fails = 0; idle_pct = 0; stall_pct = 0;
		arst_n = 0; wr_en = 0; wr_index = CFG_TARGET_X; wr_data = '0;
		vertices.valid = 0; vertices.vertex_x = '0; vertices.vertex_y = '0;
		vertices.first_vertex = 0; vertices.last_vertex = 0;
		tgt_x = 0; tgt_y = 0; prv_x = 0; prv_y = 0;
		clear_bests();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		dir_rows = '{
			'{0, 0, 1, 1, 1, '{0, 0, 0, 0}},
			'{256, 0, 1, 1, 1, '{256, 0, 65536, 0}},
			'{-256, 256, 1, 0, 0, none},
			'{256, 256, 0, 1, 1, '{0, 256, 65536, 1}},
			'{0, 512, 1, 0, 0, none},
			'{0, -512, 0, 1, 1, '{0, 0, 0, 1}},
			'{100, 100, 1, 0, 0, none},
			'{100, 100, 0, 1, 1, '{100, 100, 20000, 0}},
			'{24'h7FFFFF, 24'h7FFFFF, 1, 1, 1, '{24'h7FFFFF, 24'h7FFFFF,
				50'd140737454800898, 0}},
			'{24'h800000, 24'h800000, 1, 1, 1, '{24'h800000, 24'h800000,
				50'd140737488355328, 0}},
			'{24'h800000, 24'h7FFFFF, 1, 0, 0, none},
			'{24'h7FFFFF, 24'h800000, 0, 1, 0, none},
			'{500, 3, 0, 0, 0, none},
			'{-7, 9, 0, 1, 0, none}
		};
		foreach (dir_rows[i])
			send_vertex(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].first,
				dir_rows[i].last, dir_rows[i].check, dir_rows[i].want);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 61; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 61; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			case (ph)
				0: write_reg(CFG_TARGET_X, 24'sh7FFFFF);
				1: write_reg(CFG_TARGET_Y, -24'sh800000);
				2: write_reg(CFG_TARGET_X, -24'sh800000);
				3: write_reg(CFG_TARGET_Y, 24'sh7FFFFF);
				default: begin
					write_reg(CFG_TARGET_X, $signed($urandom_range(8000)) - 4000);
					write_reg(CFG_TARGET_Y, $signed($urandom_range(8000)) - 4000);
				end
			endcase
			span = (ph < 4) ? 8388607 : 5000;
			n = 0;
			while (n < 100) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send_vertex(rnd_coord(span), rnd_coord(span),
						(k == 0) && ($urandom_range(9) != 0),
						(k == len - 1) && ($urandom_range(9) != 0), 0, none);
					n++;
				end
			end
			drain();
		end
		if (fails == 0 && nearest_q.size() == 0)
			$display("polyline_nearest_point_core: match");
		else
			$display("polyline_nearest_point_core: mismatch");
		$finish;
	end
endmodule

// File: polyline_nearest_point_core.f
src/plnp_pkg.sv
src/plnp_in_if.sv
src/plnp_out_if.sv
src/plnp_foot.sv
src/plnp_datapath.sv
src/plnp_ctrl.sv
src/polyline_nearest_point_core.sv
src/plnp_checker.sv
tb/sv/polyline_nearest_point_core_tb.sv
